@@ rtl/pkf_pkg.sv @@
`default_nettype none

package pkf_pkg;

  // Verdict codes.
  localparam logic [1:0] VERDICT_ACCEPT    = 2'd0;
  localparam logic [1:0] VERDICT_SHORT     = 2'd1;
  localparam logic [1:0] VERDICT_NOT_IPV4  = 2'd2;
  localparam logic [1:0] VERDICT_NOT_TCP   = 2'd3;

  // Knock machine stages.
  localparam logic [1:0] KS_CLOSED0 = 2'd0;
  localparam logic [1:0] KS_CLOSED1 = 2'd1;
  localparam logic [1:0] KS_CLOSED2 = 2'd2;
  localparam logic [1:0] KS_OPEN    = 2'd3;

  // Register indexes.
  localparam logic [1:0] REG_KNOCK_FIRST  = 2'd0;
  localparam logic [1:0] REG_KNOCK_SECOND = 2'd1;
  localparam logic [1:0] REG_KNOCK_THIRD  = 2'd2;

  localparam logic [15:0] KNOCK_FIRST_RST  = 16'd100;
  localparam logic [15:0] KNOCK_SECOND_RST = 16'd101;
  localparam logic [15:0] KNOCK_THIRD_RST  = 16'd102;

  // Packet layout; the *_REL offsets are relative to the start of the Ethernet header.
  localparam int unsigned HIST_BASE   = 14;
  localparam int unsigned HIST_LEN    = 12;
  localparam int unsigned ETYPE_REL   = 12;
  localparam int unsigned PROTO_REL   = 23;
  localparam int unsigned DPORT_REL   = 36;
  localparam int unsigned MIN_REL     = 54;
  localparam int unsigned HIST_PORT_LO = 10;
  localparam int unsigned HIST_PORT_HI = 11;

  localparam logic [7:0] ETYPE_HI  = 8'h08;
  localparam logic [7:0] ETYPE_LO  = 8'h00;
  localparam logic [7:0] PROTO_TCP = 8'd6;

  typedef struct packed {
    logic [15:0] first;
    logic [15:0] second;
    logic [15:0] third;
  } knock_cfg_t;

  function automatic logic [1:0] knock_step(input logic [1:0] st, input logic [15:0] port,
                                            input knock_cfg_t kc);
    logic [1:0] res;
    res = KS_CLOSED0;
    priority if (st == KS_OPEN) begin
      res = KS_OPEN;
    end else if (st == KS_CLOSED0 && port == kc.first) begin
      res = KS_CLOSED1;
    end else if (st == KS_CLOSED1 && port == kc.second) begin
      res = KS_CLOSED2;
    end else if (st == KS_CLOSED2 && port == kc.third) begin
      res = KS_OPEN;
    end else begin
      res = KS_CLOSED0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/port_knock_filter_with_history_top.sv @@
// Channel | Direction | Ports                                             | Handshake
// input   | in        | in_packet_byte, in_last_byte                      | in_valid / in_ready
// result  | out       | out_verdict, out_knock_state, out_current_dst_port| out_valid / out_ready
// config  | in/out    | psel, penable, pwrite, paddr, pwdata, prdata      | pready tied high
//
// The block takes one byte per cycle while in_ready is high. After the last byte of an accepted
// packet the CORES-1 history entries are read one a cycle through the registered read port and
// step the knock machine, then the current port does, and the result is loaded before the
// next word is taken; any other verdict goes straight to the result load. A result waiting in
// the output register does not hold off the next packet's bytes, only the next result load.
// Reset is synchronous and active low; the history memory is not cleared.
`default_nettype none

module port_knock_filter_with_history_top #(
  parameter int CORES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_packet_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_verdict,
  output logic [1:0]       out_knock_state,
  output logic [15:0]      out_current_dst_port,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int HDEPTH   = (CORES > 1) ? CORES - 1 : 1;
  localparam bit HAS_HIST = (CORES > 1);
  localparam int IW       = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
  localparam int RW       = $clog2(HDEPTH + 1);

  localparam logic [15:0] HIST_START = 16'(pkf_pkg::HIST_BASE);
  localparam logic [15:0] PKT_BASE   = 16'(pkf_pkg::HIST_BASE + pkf_pkg::HIST_LEN * (CORES - 1));
  localparam logic [15:0] ETYPE_OFF  = PKT_BASE + 16'(pkf_pkg::ETYPE_REL);
  localparam logic [15:0] PROTO_OFF  = PKT_BASE + 16'(pkf_pkg::PROTO_REL);
  localparam logic [15:0] DPORT_OFF  = PKT_BASE + 16'(pkf_pkg::DPORT_REL);
  localparam logic [15:0] MIN_LEN_M1 = PKT_BASE + 16'(pkf_pkg::MIN_REL - 1);
  localparam logic [3:0]  OFF_LO     = 4'(pkf_pkg::HIST_PORT_LO);
  localparam logic [3:0]  OFF_HI     = 4'(pkf_pkg::HIST_PORT_HI);
  localparam logic [3:0]  OFF_END    = 4'(pkf_pkg::HIST_LEN - 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(HDEPTH - 1);

  localparam logic [1:0] S_RUN    = 2'd0;
  localparam logic [1:0] S_REPLAY = 2'd1;
  localparam logic [1:0] S_DST    = 2'd2;
  localparam logic [1:0] S_FIN    = 2'd3;

  logic [1:0]  state_r;
  logic [15:0] byte_cnt_r;
  logic        eth_ok_r;
  logic        proto_ok_r;
  logic [15:0] dst_r;
  logic [3:0]  off_r;
  logic [RW-1:0] rec_r;
  logic [7:0]  hist_lo_r;
  logic [1:0]  stage_r;
  pkf_pkg::knock_cfg_t kcfg_r;

  logic [IW-1:0] rd_idx_r;
  logic [IW-1:0] knk_idx_r;
  logic          iss_done_r;
  logic          rd_v_r;
  logic [15:0]   mem_q_r;
  logic [15:0]   hist_mem [HDEPTH];

  logic [1:0]  verd_r;
  logic [15:0] port_r;

  logic        out_valid_r;
  logic [1:0]  out_verd_r;
  logic [1:0]  out_stage_r;
  logic [15:0] out_port_r;

  logic        in_fire;
  logic        in_hist;
  logic        mem_we;
  logic        mem_re;
  logic        eth_ok_nxt;
  logic        proto_ok_nxt;
  logic [15:0] dst_nxt;
  logic        out_free;
  logic        out_load;
  logic        cfg_we;

  assign in_ready = (state_r == S_RUN);
  assign in_fire  = in_valid && in_ready;
  assign in_hist  = HAS_HIST && (byte_cnt_r >= HIST_START) && (byte_cnt_r < PKT_BASE);
  assign mem_we   = in_fire && in_hist && (off_r == OFF_HI);
  assign mem_re   = (state_r == S_REPLAY) && !iss_done_r;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = (state_r == S_FIN) && out_free;
  assign cfg_we   = psel && penable && pwrite;

  always_comb begin
    eth_ok_nxt   = eth_ok_r;
    proto_ok_nxt = proto_ok_r;
    dst_nxt      = dst_r;
    if (byte_cnt_r == ETYPE_OFF) begin
      eth_ok_nxt = (in_packet_byte == pkf_pkg::ETYPE_HI);
    end else if (byte_cnt_r == ETYPE_OFF + 16'd1) begin
      eth_ok_nxt = eth_ok_r && (in_packet_byte == pkf_pkg::ETYPE_LO);
    end
    if (byte_cnt_r == PROTO_OFF) begin
      proto_ok_nxt = (in_packet_byte == pkf_pkg::PROTO_TCP);
    end
    if (byte_cnt_r == DPORT_OFF) begin
      dst_nxt = {in_packet_byte, 8'h00};
    end else if (byte_cnt_r == DPORT_OFF + 16'd1) begin
      dst_nxt = {dst_r[15:8], in_packet_byte};
    end
  end

  // History memory: one write port from the byte stream, one registered read port for replay.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[rec_r[IW-1:0]] <= {in_packet_byte, hist_lo_r};
    end
    if (mem_re) begin
      mem_q_r <= hist_mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      byte_cnt_r  <= '0;
      eth_ok_r    <= 1'b0;
      proto_ok_r  <= 1'b0;
      dst_r       <= '0;
      off_r       <= '0;
      rec_r       <= '0;
      stage_r     <= pkf_pkg::KS_CLOSED0;
      rd_idx_r    <= '0;
      knk_idx_r   <= '0;
      iss_done_r  <= 1'b0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      kcfg_r.first  <= pkf_pkg::KNOCK_FIRST_RST;
      kcfg_r.second <= pkf_pkg::KNOCK_SECOND_RST;
      kcfg_r.third  <= pkf_pkg::KNOCK_THIRD_RST;
    end else begin
      if (cfg_we) begin
        unique case (paddr[3:2])
          pkf_pkg::REG_KNOCK_FIRST:  kcfg_r.first  <= pwdata[15:0];
          pkf_pkg::REG_KNOCK_SECOND: kcfg_r.second <= pwdata[15:0];
          pkf_pkg::REG_KNOCK_THIRD:  kcfg_r.third  <= pwdata[15:0];
          default: ;
        endcase
      end

      out_valid_r <= out_load || (out_valid_r && !out_ready);

      rd_v_r <= mem_re;

      unique case (state_r)
        S_RUN: begin
          if (in_fire) begin
            if (in_last_byte) begin
              byte_cnt_r <= '0;
              eth_ok_r   <= 1'b0;
              proto_ok_r <= 1'b0;
              dst_r      <= '0;
              off_r      <= '0;
              rec_r      <= '0;
              rd_idx_r   <= '0;
              knk_idx_r  <= '0;
              iss_done_r <= 1'b0;
              priority if (byte_cnt_r < MIN_LEN_M1) begin
                verd_r  <= pkf_pkg::VERDICT_SHORT;
                port_r  <= '0;
                state_r <= S_FIN;
              end else if (!eth_ok_nxt) begin
                verd_r  <= pkf_pkg::VERDICT_NOT_IPV4;
                port_r  <= dst_nxt;
                state_r <= S_FIN;
              end else if (!proto_ok_nxt) begin
                verd_r  <= pkf_pkg::VERDICT_NOT_TCP;
                port_r  <= dst_nxt;
                state_r <= S_FIN;
              end else begin
                verd_r  <= pkf_pkg::VERDICT_ACCEPT;
                port_r  <= dst_nxt;
                state_r <= HAS_HIST ? S_REPLAY : S_DST;
              end
            end else begin
              if (in_hist) begin
                if (off_r == OFF_LO) begin
                  hist_lo_r <= in_packet_byte;
                end
                if (off_r == OFF_END) begin
                  off_r <= '0;
                  rec_r <= rec_r + RW'(1);
                end else begin
                  off_r <= off_r + 4'd1;
                end
              end
              eth_ok_r   <= eth_ok_nxt;
              proto_ok_r <= proto_ok_nxt;
              dst_r      <= dst_nxt;
              if (byte_cnt_r != 16'hFFFF) begin
                byte_cnt_r <= byte_cnt_r + 16'd1;
              end
            end
          end
        end
        S_REPLAY: begin
          if (!iss_done_r) begin
            rd_idx_r <= rd_idx_r + IW'(1);
            if (rd_idx_r == LAST_IDX) begin
              iss_done_r <= 1'b1;
            end
          end
          if (rd_v_r) begin
            stage_r   <= pkf_pkg::knock_step(stage_r, mem_q_r, kcfg_r);
            knk_idx_r <= knk_idx_r + IW'(1);
            if (knk_idx_r == LAST_IDX) begin
              state_r <= S_DST;
            end
          end
        end
        S_DST: begin
          stage_r <= pkf_pkg::knock_step(stage_r, port_r, kcfg_r);
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_verd_r  <= verd_r;
            out_stage_r <= stage_r;
            out_port_r  <= port_r;
            state_r     <= S_RUN;
          end
        end
        default: state_r <= S_RUN;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      pkf_pkg::REG_KNOCK_FIRST:  prdata = {16'h0000, kcfg_r.first};
      pkf_pkg::REG_KNOCK_SECOND: prdata = {16'h0000, kcfg_r.second};
      pkf_pkg::REG_KNOCK_THIRD:  prdata = {16'h0000, kcfg_r.third};
      default:                   prdata = '0;
    endcase
  end

  assign pready               = 1'b1;
  assign out_valid            = out_valid_r;
  assign out_verdict          = out_verd_r;
  assign out_knock_state      = out_stage_r;
  assign out_current_dst_port = out_port_r;

  // A new result only appears after the result-load state.
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the load state");

  // Read data comes back only while the replay is running.
  a_read_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> state_r == S_REPLAY)
    else $error("history read data outside replay");

  // History writes only come from accepted words of the byte stream.
  a_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_RUN) && in_valid && in_hist)
    else $error("history write without an accepted word");

  // Once open, the knock machine stays open.
  a_open_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stage_r == pkf_pkg::KS_OPEN |=> stage_r == pkf_pkg::KS_OPEN)
    else $error("knock machine left the open stage");

endmodule

`default_nettype wire

@@ tb/sv/port_knock_filter_with_history_top_tb.sv @@
`timescale 1ns / 100ps

module port_knock_filter_with_history_top_tb;
  import pkf_pkg::*;

  localparam int CORES = 4;
  localparam int unsigned PKT_BASE = HIST_BASE + HIST_LEN * (CORES - 1);
  localparam int unsigned ETYPE_POS = PKT_BASE + ETYPE_REL;
  localparam int unsigned PROTO_POS = PKT_BASE + PROTO_REL;
  localparam int unsigned DPORT_POS = PKT_BASE + DPORT_REL;
  localparam int unsigned MIN_LEN = PKT_BASE + MIN_REL;
  localparam logic [15:0] ETHERTYPE_IPV4 = {ETYPE_HI, ETYPE_LO};
  localparam logic [3:0] ADDR_FIRST = {REG_KNOCK_FIRST, 2'b00};
  localparam logic [3:0] ADDR_SECOND = {REG_KNOCK_SECOND, 2'b00};
  localparam logic [3:0] ADDR_THIRD = {REG_KNOCK_THIRD, 2'b00};
  localparam logic [3:0] ADDR_UNUSED = 4'd12;
  localparam int DRAIN_CYCLES = CORES + 6;
  localparam int PASS_FLUSH_CYCLES = 20;
  localparam int REPORT_LIMIT = 10;

  // Slot CORES-1 holds the TCP destination port, the lower slots the history records.
  typedef logic [CORES-1:0][15:0] port_set_t;

  typedef struct {
    logic [1:0] verdict;
    logic [1:0] knock;
    logic [15:0] port;
  } knock_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_packet_byte = 8'h00;
  logic in_last_byte = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_verdict;
  logic [1:0] out_knock_state;
  logic [15:0] out_current_dst_port;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic pready;

  // Shadow of the filter state.
  logic [15:0] cfg_first = KNOCK_FIRST_RST;
  logic [15:0] cfg_second = KNOCK_SECOND_RST;
  logic [15:0] cfg_third = KNOCK_THIRD_RST;
  logic [15:0] rx_count = 16'd0;
  logic [15:0] hist_port [CORES-1] = '{default: 16'd0};
  logic [15:0] cur_dst_port = 16'd0;
  logic etype_match = 1'b0;
  logic proto_match = 1'b0;
  logic [1:0] knock_now = KS_CLOSED0;

  knock_result_t pending_results[$];
  logic [7:0] pkt_bytes[$];
  int mismatches = 0;
  int bytes_sent = 0;
  int hold_left = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;

  port_knock_filter_with_history_top #(
    .CORES(CORES)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_packet_byte(in_packet_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_verdict(out_verdict),
    .out_knock_state(out_knock_state),
    .out_current_dst_port(out_current_dst_port),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The long receiver hold-off counts down here; the test only loads it.
  always @(negedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(negedge clk) begin
    out_ready <= (hold_left == 0) && (!rx_idle_en || $urandom_range(99) >= 22);
  end

  function automatic logic [1:0] next_knock(logic [1:0] st, logic [15:0] port);
    case (st)
      KS_OPEN: return KS_OPEN;
      KS_CLOSED0: return (port == cfg_first) ? KS_CLOSED1 : KS_CLOSED0;
      KS_CLOSED1: return (port == cfg_second) ? KS_CLOSED2 : KS_CLOSED0;
      default: return (port == cfg_third) ? KS_OPEN : KS_CLOSED0;
    endcase
  endfunction

  // Advances the shadow state by one accepted word and queues the verdict on the last one.
  function automatic void track_byte(logic [7:0] b, logic last);
    int unsigned pos;
    int unsigned rel;
    knock_result_t res;
    pos = rx_count;
    if (pos >= HIST_BASE && pos < PKT_BASE) begin
      rel = pos - HIST_BASE;
      if (rel % HIST_LEN == HIST_PORT_LO) hist_port[rel / HIST_LEN][7:0] = b;
      else if (rel % HIST_LEN == HIST_PORT_HI) hist_port[rel / HIST_LEN][15:8] = b;
    end
    if (pos == ETYPE_POS) etype_match = (b == ETYPE_HI);
    else if (pos == ETYPE_POS + 1) etype_match = etype_match && (b == ETYPE_LO);
    if (pos == PROTO_POS) proto_match = (b == PROTO_TCP);
    if (pos == DPORT_POS) cur_dst_port = {b, 8'h00};
    else if (pos == DPORT_POS + 1) cur_dst_port[7:0] = b;
    if (rx_count != 16'hFFFF) rx_count = rx_count + 16'd1;
    if (last) begin
      res.port = cur_dst_port;
      if (pos + 1 < MIN_LEN) begin
        res.verdict = VERDICT_SHORT;
        res.port = 16'd0;
      end else if (!etype_match) begin
        res.verdict = VERDICT_NOT_IPV4;
      end else if (!proto_match) begin
        res.verdict = VERDICT_NOT_TCP;
      end else begin
        res.verdict = VERDICT_ACCEPT;
        for (int i = 0; i < CORES - 1; i++) knock_now = next_knock(knock_now, hist_port[i]);
        knock_now = next_knock(knock_now, cur_dst_port);
      end
      res.knock = knock_now;
      pending_results.push_back(res);
      rx_count = 16'd0;
      cur_dst_port = 16'd0;
      etype_match = 1'b0;
      proto_match = 1'b0;
    end
  endfunction

  function automatic void report_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t: mismatch: %s", $time, msg);
  endfunction

  always @(posedge clk) begin : result_check
    knock_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result: verdict %0d state %0d port %04h",
                                  out_verdict, out_knock_state, out_current_dst_port));
      end else begin
        want = pending_results.pop_front();
        if (out_verdict !== want.verdict || out_knock_state !== want.knock ||
            out_current_dst_port !== want.port)
          report_mismatch($sformatf(
              "expected verdict %0d state %0d port %04h, got verdict %0d state %0d port %04h",
              want.verdict, want.knock, want.port,
              out_verdict, out_knock_state, out_current_dst_port));
      end
    end
  end

  function automatic logic [15:0] pick_port();
    case ($urandom_range(3))
      0: return cfg_first;
      1: return cfg_second;
      2: return cfg_third;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_cfg_value();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Picks knock ports that move the machine around without opening it, since open latches.
  function automatic port_set_t choose_ports();
    port_set_t ports;
    logic [1:0] st;
    logic [15:0] spare;
    for (int tries = 0; tries < 16; tries++) begin
      for (int i = 0; i < CORES; i++) ports[i] = pick_port();
      st = knock_now;
      for (int i = 0; i < CORES; i++) st = next_knock(st, ports[i]);
      if (st != KS_OPEN) return ports;
    end
    do spare = 16'($urandom); while (spare == cfg_first || spare == cfg_second ||
                                     spare == cfg_third);
    return {CORES{spare}};
  endfunction

  function automatic void place(int unsigned pos, logic [7:0] v);
    if (pos < pkt_bytes.size()) pkt_bytes[pos] = v;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while (tx_idle_en && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_packet_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    track_byte(b, last);
    bytes_sent++;
  endtask

  // Builds a packet of random bytes with the header fields laid over it, then sends it.
  task automatic send_frame(input int unsigned len, input logic [15:0] etype,
                            input logic [7:0] proto, input port_set_t ports);
    pkt_bytes.delete();
    for (int unsigned i = 0; i < len; i++) pkt_bytes.push_back(8'($urandom));
    for (int r = 0; r < CORES - 1; r++) begin
      place(HIST_BASE + HIST_LEN * r + HIST_PORT_LO, ports[r][7:0]);
      place(HIST_BASE + HIST_LEN * r + HIST_PORT_HI, ports[r][15:8]);
    end
    place(ETYPE_POS, etype[15:8]);
    place(ETYPE_POS + 1, etype[7:0]);
    place(PROTO_POS, proto);
    place(DPORT_POS, ports[CORES-1][15:8]);
    place(DPORT_POS + 1, ports[CORES-1][7:0]);
    for (int i = 0; i < pkt_bytes.size(); i++) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_knock_reg(input logic [3:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (addr)
      ADDR_FIRST: cfg_first = data[15:0];
      ADDR_SECOND: cfg_second = data[15:0];
      ADDR_THIRD: cfg_third = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_packet();
    int unsigned kind;
    int unsigned len;
    logic [15:0] etype;
    logic [7:0] proto;
    kind = $urandom_range(99);
    etype = ETHERTYPE_IPV4;
    proto = PROTO_TCP;
    len = MIN_LEN + (($urandom_range(3) == 0) ? $urandom_range(12) : 0);
    if (kind < 30) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(MIN_LEN - 1, 21) : $urandom_range(20, 1);
    end else if (kind < 38) begin
      do etype = 16'($urandom); while (etype == ETHERTYPE_IPV4);
    end else if (kind < 44) begin
      etype = {ETYPE_HI, 8'($urandom_range(255, 1))};
    end else if (kind < 52) begin
      do proto = 8'($urandom); while (proto == PROTO_TCP);
    end
    send_frame(len, etype, proto, choose_ports());
  endtask

  task automatic test_short_packets();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_frame(MIN_LEN - 1, ETHERTYPE_IPV4, PROTO_TCP, {16'd100, 16'd0, 16'd0, 16'd0});
  endtask

  task automatic test_header_checks();
    send_frame(MIN_LEN, 16'h0801, PROTO_TCP, {16'hA55A, 16'd1, 16'd2, 16'd3});
    send_frame(MIN_LEN, ETHERTYPE_IPV4, 8'd17, {16'hFFFF, 16'd1, 16'd2, 16'd3});
    send_frame(MIN_LEN + 5, 16'h0000, 8'hFF, {16'h1234, 16'd1, 16'd2, 16'd3});
    send_frame(MIN_LEN, ETHERTYPE_IPV4, PROTO_TCP, {16'hFFFF, 16'd0, 16'd0, 16'd0});
  endtask

  // Runs on the reset port values: 0 -> 1 -> 0 -> 1 -> 2, a rejected packet, then back to 0.
  task automatic test_knock_stages();
    send_frame(MIN_LEN, ETHERTYPE_IPV4, PROTO_TCP, {16'd101, 16'd100, 16'd555, 16'd100});
    send_frame(MIN_LEN, ETHERTYPE_IPV4, 8'd0, {16'd102, 16'd102, 16'd102, 16'd102});
    send_frame(MIN_LEN, ETHERTYPE_IPV4, PROTO_TCP, {16'd100, 16'd100, 16'd7, 16'd101});
  endtask

  task automatic test_register_writes();
    drain();
    write_knock_reg(ADDR_FIRST, 32'hDEAD_0000);
    write_knock_reg(ADDR_SECOND, 32'h0000_FFFF);
    write_knock_reg(ADDR_THIRD, 32'hFFFF_8001);
    write_knock_reg(ADDR_UNUSED, 32'h0000_0064);
    send_frame(MIN_LEN, ETHERTYPE_IPV4, PROTO_TCP, {16'h0000, 16'h0005, 16'hFFFF, 16'h0000});
    drain();
    write_knock_reg(ADDR_FIRST, 32'h0000_FFFF);
    write_knock_reg(ADDR_SECOND, 32'hFFFF_FFFF);
    write_knock_reg(ADDR_THIRD, 32'h0000_FFFF);
    send_frame(MIN_LEN, ETHERTYPE_IPV4, PROTO_TCP, {16'd7, 16'hFFFF, 16'd7, 16'hFFFF});
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      write_knock_reg(ADDR_FIRST, {16'($urandom), pick_cfg_value()});
      write_knock_reg(ADDR_SECOND, {16'($urandom), pick_cfg_value()});
      write_knock_reg(ADDR_THIRD, {16'($urandom), pick_cfg_value()});
      // One phase runs with both sides streaming at full rate.
      tx_idle_en = (phase != 2);
      rx_idle_en = (phase != 2);
      for (int n = 0; n < 2; n++) random_packet();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_output_backpressure();
    tx_idle_en = 1'b0;
    send_byte(8'h3C, 1'b1);
    hold_left = 300;
    for (int n = 0; n < 8; n++)
      send_frame($urandom_range(3, 1), ETHERTYPE_IPV4, PROTO_TCP, choose_ports());
    send_frame(MIN_LEN, ETHERTYPE_IPV4, PROTO_TCP, choose_ports());
    tx_idle_en = 1'b1;
  endtask

  task automatic test_open_latch();
    drain();
    write_knock_reg(ADDR_FIRST, 32'h0000_FFFF);
    write_knock_reg(ADDR_SECOND, 32'h0000_0000);
    write_knock_reg(ADDR_THIRD, 32'h0000_8000);
    send_frame(MIN_LEN, ETHERTYPE_IPV4, PROTO_TCP, {16'h8000, 16'h0000, 16'hFFFF, 16'h1234});
    send_frame(MIN_LEN, 16'h86DD, PROTO_TCP, {16'd1, 16'd2, 16'd3, 16'd4});
    send_frame(10, ETHERTYPE_IPV4, PROTO_TCP, {16'd1, 16'd2, 16'd3, 16'd4});
    drain();
    write_knock_reg(ADDR_FIRST, {16'($urandom), pick_cfg_value()});
    write_knock_reg(ADDR_SECOND, {16'($urandom), pick_cfg_value()});
    write_knock_reg(ADDR_THIRD, {16'($urandom), pick_cfg_value()});
    send_frame(MIN_LEN, ETHERTYPE_IPV4, PROTO_TCP, {16'd9, 16'd9, 16'd9, 16'd9});
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_short_packets();
    test_header_checks();
    test_knock_stages();
    test_register_writes();
    test_random_traffic();
    test_output_backpressure();
    test_open_latch();
    drain();
    repeat (PASS_FLUSH_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("port_knock_filter_with_history_top regression: pass");
    end else begin
      $display("port_knock_filter_with_history_top regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("port_knock_filter_with_history_top regression: fail");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/pkf_pkg.sv
rtl/port_knock_filter_with_history_top.sv
tb/sv/port_knock_filter_with_history_top_tb.sv
